[src/msrl_pkg.sv]
// Shared types and constants for the mark/space run-length decoder.
package msrl_pkg;

	// Largest number of runs given out per body
	localparam int MAX_DURATIONS = 1024;
	localparam int RUNS_W        = $clog2(MAX_DURATIONS + 1);

	// Byte layout and scaling
	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 7;
	localparam int POL_BIT  = 7;
	localparam int UNIT_SH  = 4;               // 16 us per length unit
	localparam int US_W     = LEN_W + UNIT_SH; // one byte's length in us
	localparam int DUR_W    = 16;
	localparam logic [DUR_W-1:0] DUR_SAT = '1;

	// Result queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Number of results pushed for one byte
	typedef enum logic [1:0] {
		PUSH_NONE = 2'd0,
		PUSH_ONE  = 2'd1,
		PUSH_TWO  = 2'd2
	} push_num_t;

	// One result word
	typedef struct packed {
		logic [DUR_W-1:0] duration_us;
		logic             is_mark;
		logic             final_run;
	} result_t;

	// Push request from front to queue
	typedef struct packed {
		push_num_t num;
		result_t   first;
		result_t   second;
	} push_req_t;

	// Queue head towards the back
	typedef struct packed {
		logic    not_empty;
		result_t head;
	} queue_head_t;

endpackage

[src/msrl_front.sv]
// Front part: takes body bytes, merges runs and pushes finished runs.
module msrl_front
	import msrl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] code_byte,
	input  logic              body_end,
	input  logic [QCNT_W-1:0] q_count,
	output push_req_t         push
);

	logic              run_open_q;
	logic              run_pol_q;
	logic [DUR_W-1:0]  run_accum_q;
	logic [RUNS_W-1:0] runs_q;

	logic              open_d;
	logic              pol_d;
	logic [DUR_W-1:0]  accum_d;
	logic [RUNS_W-1:0] runs_d;
	logic              accept;
	logic              byte_pol;
	logic [US_W-1:0]   byte_us;
	logic [DUR_W:0]    sum;
	logic [DUR_W-1:0]  merged;
	logic              capped;
	logic              cap_hit;
	push_req_t         push_c;

	// Room for two results is needed before a byte is taken
	assign in_stall = (q_count > QCNT_W'(QDEPTH - 2));
	assign accept   = in_valid && !in_stall;

	assign byte_pol = code_byte[POL_BIT];
	assign byte_us  = {code_byte[LEN_W-1:0], {UNIT_SH{1'b0}}};

	// Saturating merge of the byte into the open run
	assign sum    = {1'b0, run_accum_q} + {{(DUR_W + 1 - US_W){1'b0}}, byte_us};
	assign merged = sum[DUR_W] ? DUR_SAT : sum[DUR_W-1:0];

	assign capped  = (runs_q >= RUNS_W'(MAX_DURATIONS));
	assign cap_hit = ((runs_q + RUNS_W'(1)) >= RUNS_W'(MAX_DURATIONS));

	// Classify the byte: next run state and results to push
	always_comb begin
		open_d  = run_open_q;
		pol_d   = run_pol_q;
		accum_d = run_accum_q;
		runs_d  = runs_q;
		push_c  = '{num: PUSH_NONE, first: '0, second: '0};
		if (capped) begin
			// past the cap: bytes ignored until the body ends
		end else if (run_open_q && (byte_pol == run_pol_q)) begin
			accum_d = merged;
			if (body_end) begin
				push_c.num   = PUSH_ONE;
				push_c.first = '{duration_us: merged, is_mark: run_pol_q, final_run: 1'b1};
			end
		end else if (run_open_q && cap_hit) begin
			// closing run reaches the cap
			push_c.num   = PUSH_ONE;
			push_c.first = '{duration_us: run_accum_q, is_mark: run_pol_q, final_run: 1'b1};
			runs_d       = runs_q + RUNS_W'(1);
		end else begin
			open_d  = 1'b1;
			pol_d   = byte_pol;
			accum_d = {{(DUR_W - US_W){1'b0}}, byte_us};
			if (run_open_q) begin
				push_c.num   = PUSH_ONE;
				push_c.first = '{duration_us: run_accum_q, is_mark: run_pol_q,
					final_run: 1'b0};
				runs_d       = runs_q + RUNS_W'(1);
				if (body_end) begin
					push_c.num    = PUSH_TWO;
					push_c.second = '{duration_us: {{(DUR_W - US_W){1'b0}}, byte_us},
						is_mark: byte_pol, final_run: 1'b1};
				end
			end else if (body_end) begin
				push_c.num   = PUSH_ONE;
				push_c.first = '{duration_us: {{(DUR_W - US_W){1'b0}}, byte_us},
					is_mark: byte_pol, final_run: 1'b1};
			end
		end
		// end of body returns to the start-of-body state
		if (body_end) begin
			open_d  = 1'b0;
			pol_d   = 1'b0;
			accum_d = '0;
			runs_d  = '0;
		end
	end

	// Push only for accepted bytes
	always_comb begin
		push = push_c;
		if (!accept) begin
			push.num = PUSH_NONE;
		end
	end

	// Run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_open_q  <= 1'b0;
			run_pol_q   <= 1'b0;
			run_accum_q <= '0;
			runs_q      <= '0;
		end else if (accept) begin
			run_open_q  <= open_d;
			run_pol_q   <= pol_d;
			run_accum_q <= accum_d;
			runs_q      <= runs_d;
		end
	end

	// A byte that ends the body leaves the run count cleared
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && body_end) |=> (runs_q == '0 && !run_open_q))
		else $error("run state not cleared at end of body");

	// Nothing is given out past the cap
	a_capped_silent: assert property (@(posedge clk) disable iff (!arst_n)
		capped |-> (push.num == PUSH_NONE))
		else $error("result pushed past the cap");

	// Run count never passes the cap
	a_runs_bound: assert property (@(posedge clk) disable iff (!arst_n)
		runs_q <= RUNS_W'(MAX_DURATIONS))
		else $error("run count beyond cap");

endmodule

[src/msrl_queue.sv]
// Result queue: up to two words in, one word out per cycle.
module msrl_queue
	import msrl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  push_req_t         push,
	input  logic              pop,
	output queue_head_t       q_head,
	output logic [QCNT_W-1:0] q_count
);

	result_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic [QCNT_W-1:0] push_cnt;
	logic [QPTR_W-1:0] wr_ptr_nx;

	always_comb begin
		unique case (push.num)
			PUSH_ONE: push_cnt = QCNT_W'(1);
			PUSH_TWO: push_cnt = QCNT_W'(2);
			default:  push_cnt = '0;
		endcase
	end

	assign wr_ptr_nx = wr_ptr_q + QPTR_W'(1);

	// Storage
	always_ff @(posedge clk) begin
		if (push.num == PUSH_ONE || push.num == PUSH_TWO) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.num == PUSH_TWO) begin
			mem_q[wr_ptr_nx] <= push.second;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_cnt[QPTR_W-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + push_cnt - QCNT_W'(pop);
		end
	end

	assign q_head.not_empty = (count_q != '0);
	assign q_head.head      = mem_q[rd_ptr_q];
	assign q_count          = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("result queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("pop from empty result queue");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(push.num != PUSH_NONE) |-> ((count_q + push_cnt) <= QCNT_W'(QDEPTH)))
		else $error("push without room in result queue");

endmodule

[src/msrl_back.sv]
// Back part: output register fed from the result queue.
module msrl_back
	import msrl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  queue_head_t      q_head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [DUR_W-1:0] duration_us,
	output logic             is_mark,
	output logic             final_run
);

	logic    out_valid_q;
	result_t out_q;

	// Load a new word when the register is empty or being taken
	assign pop = q_head.not_empty && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= q_head.not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= q_head.head;
		end
	end

	assign out_valid   = out_valid_q;
	assign duration_us = out_q.duration_us;
	assign is_mark     = out_q.is_mark;
	assign final_run   = out_q.final_run;

endmodule

[src/mark_space_run_length_decoder.sv]
// Top level of the mark/space run-length decoder.
//
// Input channel: one body byte per word (code_byte, body_end) under
// in_valid/in_stall. Bit 7 of code_byte is the polarity, bits 6..0 a length
// in 16 us units; bytes of equal polarity merge into one run.
// Output channel: one run per word (duration_us, is_mark, final_run) under
// out_valid/out_stall; final_run marks the last run of a body or the run
// that reaches MAX_DURATIONS.
// Throughput: one byte per cycle while in_stall is low. A byte yields zero,
// one or two runs; the output port gives one run per cycle while out_stall
// is low, so a stream that yields two runs per byte is limited by the
// output port. A run pushed by an accepted byte is written into the
// four-word result queue at the accepting edge and is then loaded into
// the output register once that register is empty or being taken.
// in_stall rises when the result queue has fewer than two free words, so
// a stalled receiver fills the queue and then holds off the sender.
// Reset clears the run state, the queue pointers and count, and the output valid flag.
module mark_space_run_length_decoder
	import msrl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] code_byte,
	input  logic              body_end,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DUR_W-1:0]  duration_us,
	output logic              is_mark,
	output logic              final_run
);

	push_req_t         push;
	queue_head_t       q_head;
	logic [QCNT_W-1:0] q_count;
	logic              pop;

	msrl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.code_byte (code_byte),
		.body_end  (body_end),
		.q_count   (q_count),
		.push      (push)
	);

	msrl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.pop     (pop),
		.q_head  (q_head),
		.q_count (q_count)
	);

	msrl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_head      (q_head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.duration_us (duration_us),
		.is_mark     (is_mark),
		.final_run   (final_run)
	);

endmodule

[dv/tb_mark_space_run_length_decoder.sv]
// Self-checking testbench for the mark/space run-length decoder.
module tb_mark_space_run_length_decoder
	import msrl_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;

	// Expected-run tracker: follows the merge state and queues the runs due
	class run_scoreboard;
		result_t           runs_due[$];
		logic              run_open;
		logic              run_pol;
		int unsigned       run_accum;
		logic [RUNS_W-1:0] runs_given;
		int                errors;

		function new();
			errors = 0;
			clear_body();
		endfunction

		function void clear_body();
			run_open   = 1'b0;
			run_pol    = 1'b0;
			run_accum  = 0;
			runs_given = '0;
		endfunction

		function void push_run(logic fin);
			result_t r;
			r.duration_us = run_accum[DUR_W-1:0];
			r.is_mark     = run_pol;
			r.final_run   = fin;
			runs_due.push_back(r);
			runs_given = runs_given + 1'b1;
		endfunction

		// One accepted input word
		function void note_byte(logic [BYTE_W-1:0] code, logic last);
			logic        pol;
			logic        cap;
			int unsigned us;
			pol = code[POL_BIT];
			us  = int'(code[LEN_W-1:0]) << UNIT_SH;
			// past the cap: everything ignored until the body ends
			if (int'(runs_given) >= MAX_DURATIONS) begin
				if (last)
					clear_body();
				return;
			end
			if (run_open && pol == run_pol) begin
				run_accum = run_accum + us;
				if (run_accum > int'(DUR_SAT))
					run_accum = int'(DUR_SAT);
			end else begin
				// polarity change closes the open run
				if (run_open) begin
					cap = (int'(runs_given) + 1 >= MAX_DURATIONS);
					push_run(cap);
					if (cap) begin
						if (last)
							clear_body();
						return;
					end
				end
				run_pol   = pol;
				run_accum = us;
				run_open  = 1'b1;
			end
			if (last) begin
				push_run(1'b1);
				clear_body();
			end
		endfunction

		// One accepted output word against the oldest expectation
		function void check_run(logic [DUR_W-1:0] dur, logic mark, logic fin);
			result_t r;
			if (runs_due.size() == 0) begin
				$error("unexpected run: duration_us %0d is_mark %0b final_run %0b",
					dur, mark, fin);
				errors++;
				return;
			end
			r = runs_due.pop_front();
			if (dur !== r.duration_us) begin
				$error("duration_us: expected %0d, got %0d", r.duration_us, dur);
				errors++;
			end
			if (mark !== r.is_mark) begin
				$error("is_mark: expected %0b, got %0b", r.is_mark, mark);
				errors++;
			end
			if (fin !== r.final_run) begin
				$error("final_run: expected %0b, got %0b", r.final_run, fin);
				errors++;
			end
		endfunction

		function int pending();
			return runs_due.size();
		endfunction
	endclass

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic [BYTE_W-1:0] code_byte = '0;
	logic              body_end  = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [DUR_W-1:0]  duration_us;
	logic              is_mark;
	logic              final_run;

	run_scoreboard sb;
	int            send_gap_pct = 0;
	int            stall_pct    = 0;
	int            words_sent   = 0;
	int            cycle_count  = 0;

	mark_space_run_length_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.code_byte   (code_byte),
		.body_end    (body_end),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.duration_us (duration_us),
		.is_mark     (is_mark),
		.final_run   (final_run)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: check accepted runs, stall at random
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				sb.check_run(duration_us, is_mark, final_run);
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Drive one word; valid stays high on return
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
		if ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_gap_pct);
		end
		in_valid  <= 1'b1;
		code_byte <= b;
		body_end  <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_byte(b, last);
		words_sent++;
	endtask

	// Hold off the sender until every run is out
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Length field biased towards its extremes
	function automatic logic [LEN_W-1:0] rand_len();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return LEN_W'($urandom_range(127));
		endcase
	endfunction

	// Alternating polarity from mark, end flag on word end_idx
	task automatic send_chain(input int nbytes, input int end_idx);
		for (int i = 0; i < nbytes; i++)
			send_byte({~i[0], rand_len()}, i == end_idx);
	endtask

	// Well-formed body: alternating runs of one or more words
	task automatic send_body();
		int   nruns;
		int   nb;
		logic pol;
		nruns = $urandom_range(1, 8);
		pol   = 1'($urandom_range(1));
		for (int r = 0; r < nruns; r++) begin
			nb = ($urandom_range(11) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 4);
			for (int k = 0; k < nb; k++)
				send_byte({pol, rand_len()}, (r == nruns - 1) && (k == nb - 1));
			pol = ~pol;
		end
	endtask

	// Noise: random words, end flag at random
	task automatic send_noise();
		int nb;
		nb = $urandom_range(1, 6);
		for (int k = 0; k < nb; k++)
			send_byte(BYTE_W'($urandom_range(255)), $urandom_range(3) == 0);
	endtask

	initial begin
		int start_count;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part
		send_gap_pct = 14;
		stall_pct    = 14;
		send_byte(8'hFF, 1'b1);                 // longest single mark
		send_byte(8'h00, 1'b1);                 // zero-length space
		send_byte(8'h81, 1'b0);
		send_byte(8'h05, 1'b0);
		send_byte(8'h80, 1'b1);                 // polarity change on the last word
		for (int i = 0; i < 40; i++)            // saturated mark, then space at end
			send_byte(8'hFF, 1'b0);
		send_byte(8'h7F, 1'b1);
		for (int i = 0; i < 34; i++)            // saturated space
			send_byte(8'h7F, i == 33);
		wait_drain();

		// Cap mid-body, trailing words ignored
		send_chain(MAX_DURATIONS + 6, MAX_DURATIONS + 5);
		send_byte(8'h85, 1'b1);
		// Cap on a polarity change with body end
		send_chain(MAX_DURATIONS + 1, MAX_DURATIONS);
		// Cap reached by the end-of-body run
		send_chain(MAX_DURATIONS, MAX_DURATIONS - 1);
		send_byte(8'h03, 1'b1);
		wait_drain();

		// Random part in four phases of sender gaps and receiver stalls
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_gap_pct = 0;  stall_pct = 0;  end
				1: begin send_gap_pct = 68; stall_pct = 0;  end
				2: begin send_gap_pct = 0;  stall_pct = 68; end
				default: begin send_gap_pct = 14; stall_pct = 14; end
			endcase
			start_count = words_sent;
			while (words_sent - start_count < 240) begin
				if ($urandom_range(9) == 0)
					send_noise();
				else
					send_body();
			end
			// close any body the noise left open
			send_byte(8'h00, 1'b1);
			wait_drain();
		end

		stall_pct = 0;
		wait_drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
